/* hdl/tksi_pkg.sv */
// ============================================================================
// tksi_pkg: shared types and constants for the top-k sorted insertion list
// Field widths, the stored entry layout and the command and status groups
// that pass between the controller and the datapath.
// ============================================================================
package tksi_pkg;

   // Default number of list slots held in the entry memory.
   localparam int unsigned MAX_ENTRIES_DEF = 16;

   // Fixed field widths of the request and response channels.
   localparam int unsigned SCORE_W = 32;
   localparam int unsigned PICK_W  = 16;
   localparam int unsigned RANK_W  = 4;
   localparam int unsigned CAP_W   = 5;

   // One stored entry: the score and its three payload masks.
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [PICK_W-1:0]  pick_c;
      logic [PICK_W-1:0]  pick_b;
      logic [PICK_W-1:0]  pick_a;
   } entry_type;

   // Commands from the controller to the datapath, at most one per cycle.
   typedef struct packed {
      logic load;       // capture the request and issue the first read
      logic check_go;   // full list, candidate beats the tail: read slot i-1
      logic step;       // move slot i-1 down to slot i and read slot i-2
      logic place;      // write the candidate at slot i and respond
      logic resp_drop;  // respond that the candidate was dropped
      logic resp_read;  // respond with the entry that was read
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_read;  // the offered request is a read
      logic load_full;  // the list is full at the offered request
      logic drop;       // candidate score is not above the tail entry
      logic shift;      // slot i-1 holds a smaller score and must move down
   } sts_type;

endpackage

/* hdl/tksi_ctrl.sv */
// ============================================================================
// tksi_ctrl: sequencing state machine of the sorted insertion list
// Steps a request through the tail check, the shift walk and the read, and
// issues at most one command to the datapath per cycle.
// ============================================================================
module tksi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tksi_pkg::sts_type sts,
   output tksi_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (sts.load_read) begin
                  state_in = ST_READ;
               end else if (sts.load_full) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_CHECK: begin
            if (sts.drop) begin
               cmd.resp_drop = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.check_go = 1'b1;
               state_in     = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (sts.shift) begin
               cmd.step = 1'b1;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.resp_read = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hdl/tksi_dpath.sv */
// ============================================================================
// tksi_dpath: entry memory, counters and response registers
// Holds the sorted entries in a one-write, one-read memory, the entry count,
// the capacity register and the walk index, and builds each response.
// ============================================================================
module tksi_dpath #(
   parameter int unsigned MAX_ENTRIES = tksi_pkg::MAX_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tksi_pkg::cmd_type                cmd,
   output tksi_pkg::sts_type                sts,
   input  logic                             req_func,
   input  logic [tksi_pkg::SCORE_W-1:0]     req_score,
   input  logic [tksi_pkg::PICK_W-1:0]      req_pick_a,
   input  logic [tksi_pkg::PICK_W-1:0]      req_pick_b,
   input  logic [tksi_pkg::PICK_W-1:0]      req_pick_c,
   input  logic [tksi_pkg::RANK_W-1:0]      req_read_rank,
   input  logic                             csr_write_en,
   input  logic [tksi_pkg::CAP_W-1:0]       csr_list_capacity,
   output logic                             rsp_strobe,
   output logic                             rsp_accepted,
   output logic [tksi_pkg::RANK_W-1:0]      rsp_insert_pos,
   output logic                             rsp_entry_valid,
   output logic [tksi_pkg::SCORE_W-1:0]     rsp_entry_score,
   output logic [tksi_pkg::PICK_W-1:0]      rsp_entry_a,
   output logic [tksi_pkg::PICK_W-1:0]      rsp_entry_b,
   output logic [tksi_pkg::PICK_W-1:0]      rsp_entry_c,
   output logic [tksi_pkg::CAP_W-1:0]       rsp_entry_count
);

   localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

   tksi_pkg::entry_type entry_mem_ff [MAX_ENTRIES];
   tksi_pkg::entry_type rd_data_ff;
   tksi_pkg::entry_type new_entry_ff;
   tksi_pkg::entry_type new_entry_in;

   logic [CNT_W-1:0]             cap_ff;
   logic [CNT_W-1:0]             cap_in;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_eff;
   logic [IDX_W-1:0]             idx_ff;
   logic [IDX_W-1:0]             rd_addr;
   logic [tksi_pkg::RANK_W-1:0]  rank_ff;
   logic                         full_now;
   logic                         read_ok;

   // Count as seen by a new request, never above the capacity.
   assign count_eff = (count_ff > cap_ff) ? cap_ff : count_ff;
   assign full_now  = (count_eff == cap_ff);

   assign new_entry_in = '{score:  req_score,
                           pick_c: req_pick_c,
                           pick_b: req_pick_b,
                           pick_a: req_pick_a};

   // Status toward the controller.
   assign sts.load_read = req_func;
   assign sts.load_full = full_now;
   assign sts.drop      = !(new_entry_ff.score > rd_data_ff.score);
   assign sts.shift     = (idx_ff != '0) && (rd_data_ff.score < new_entry_ff.score);

   // Read address: the tail or the asked rank on load, then the slot above i.
   always_comb begin
      priority if (cmd.load) begin
         if (req_func) begin
            rd_addr = IDX_W'(req_read_rank);
         end else begin
            rd_addr = IDX_W'(count_eff - 1'b1);
         end
      end else if (cmd.step) begin
         rd_addr = IDX_W'(idx_ff - 2'd2);
      end else if (cmd.check_go) begin
         rd_addr = IDX_W'(idx_ff - 1'b1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Capacity write value, clamped to the slots that exist; zero counts as one.
   always_comb begin
      if (32'(csr_list_capacity) > 32'(MAX_ENTRIES)) begin
         cap_in = CNT_W'(MAX_ENTRIES);
      end else if (csr_list_capacity == '0) begin
         cap_in = CNT_W'(1);
      end else begin
         cap_in = CNT_W'(csr_list_capacity);
      end
   end

   // Read rank lies below the count and inside the memory.
   assign read_ok = (32'(rank_ff) < 32'(count_ff)) && (32'(rank_ff) < 32'(MAX_ENTRIES));

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         entry_mem_ff[idx_ff] <= rd_data_ff;
      end else if (cmd.place) begin
         entry_mem_ff[idx_ff] <= new_entry_ff;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   // Request capture and walk index.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_entry_ff <= new_entry_in;
         rank_ff      <= req_read_rank;
         if (full_now) begin
            idx_ff <= IDX_W'(count_eff - 1'b1);
         end else begin
            idx_ff <= IDX_W'(count_eff);
         end
      end else if (cmd.step) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   // Capacity and entry count. A non-full list never drops, so the count
   // grows as soon as a consider request is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CNT_W'(1);
         count_ff <= '0;
      end else if (csr_write_en) begin
         cap_ff   <= cap_in;
         count_ff <= '0;
      end else if (cmd.load && !req_func) begin
         if (full_now) begin
            count_ff <= count_eff;
         end else begin
            count_ff <= count_eff + 1'b1;
         end
      end
   end

   // Response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.place || cmd.resp_drop || cmd.resp_read;
      end
   end

   // Response fields.
   always_ff @(posedge clock) begin
      if (cmd.place || cmd.resp_drop || cmd.resp_read) begin
         rsp_accepted    <= cmd.place;
         rsp_insert_pos  <= cmd.place ? tksi_pkg::RANK_W'(idx_ff) : '0;
         rsp_entry_count <= tksi_pkg::CAP_W'(count_ff);
         if (cmd.resp_read && read_ok) begin
            rsp_entry_valid <= 1'b1;
            rsp_entry_score <= rd_data_ff.score;
            rsp_entry_a     <= rd_data_ff.pick_a;
            rsp_entry_b     <= rd_data_ff.pick_b;
            rsp_entry_c     <= rd_data_ff.pick_c;
         end else begin
            rsp_entry_valid <= 1'b0;
            rsp_entry_score <= '0;
            rsp_entry_a     <= '0;
            rsp_entry_b     <= '0;
            rsp_entry_c     <= '0;
         end
      end
   end

endmodule

/* hdl/top_k_sorted_insert.sv */
// ============================================================================
// top_k_sorted_insert: descending list of the best scored candidates
// Controller and datapath of a bounded sorted list with rank reads.
// ============================================================================
// A request is taken when start is high and busy is low; its single response
// shows on the rsp_ ports for one cycle, marked by rsp_strobe, in the first
// cycle with busy low again, and must be captured then since it is never
// held. A read passes through ST_READ alone, and a candidate dropped at a full
// list through ST_CHECK alone. Any other consider request passes through
// ST_SHIFT, one step per entry that moves down one rank, after ST_CHECK when
// the list is full for the tail compare; the walk through the entry memory
// does one read and one write per cycle. Writing the capacity empties the
// list; the user does it only while busy is low: the block does not enforce.
// ============================================================================
module top_k_sorted_insert #(
   parameter int unsigned MAX_ENTRIES = tksi_pkg::MAX_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [tksi_pkg::SCORE_W-1:0]     req_score,
   input  logic [tksi_pkg::PICK_W-1:0]      req_pick_a,
   input  logic [tksi_pkg::PICK_W-1:0]      req_pick_b,
   input  logic [tksi_pkg::PICK_W-1:0]      req_pick_c,
   input  logic [tksi_pkg::RANK_W-1:0]      req_read_rank,
   input  logic                             csr_write_en,
   input  logic [tksi_pkg::CAP_W-1:0]       csr_list_capacity,
   output logic                             rsp_strobe,
   output logic                             rsp_accepted,
   output logic [tksi_pkg::RANK_W-1:0]      rsp_insert_pos,
   output logic                             rsp_entry_valid,
   output logic [tksi_pkg::SCORE_W-1:0]     rsp_entry_score,
   output logic [tksi_pkg::PICK_W-1:0]      rsp_entry_a,
   output logic [tksi_pkg::PICK_W-1:0]      rsp_entry_b,
   output logic [tksi_pkg::PICK_W-1:0]      rsp_entry_c,
   output logic [tksi_pkg::CAP_W-1:0]       rsp_entry_count
);

   tksi_pkg::cmd_type cmd;
   tksi_pkg::sts_type sts;

   // Sequencer.
   tksi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Storage and response path.
   tksi_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_score         (req_score),
      .req_pick_a        (req_pick_a),
      .req_pick_b        (req_pick_b),
      .req_pick_c        (req_pick_c),
      .req_read_rank     (req_read_rank),
      .csr_write_en      (csr_write_en),
      .csr_list_capacity (csr_list_capacity),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted),
      .rsp_insert_pos    (rsp_insert_pos),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_entry_score   (rsp_entry_score),
      .rsp_entry_a       (rsp_entry_a),
      .rsp_entry_b       (rsp_entry_b),
      .rsp_entry_c       (rsp_entry_c),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

/* hdl/tksi_checker.sv */
// ============================================================================
// tksi_checker: port-level checks of the sorted insertion list
// Relates request acceptance, busy and the response strobe over time.
// ============================================================================
module tksi_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_accepted,
   input logic rsp_entry_valid
);

   // An accepted request always keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A response only appears once the block has finished its work.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // Every busy period ends with its response.
   a_busy_end_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy ended without a response");

   // A valid read response never reports an accepted candidate.
   a_read_not_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_valid) |-> !rsp_accepted)
      else $error("read response flagged as accepted");

endmodule

bind top_k_sorted_insert tksi_checker u_tksi_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_accepted    (rsp_accepted),
   .rsp_entry_valid (rsp_entry_valid)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Top-k sorted insertion list testbench
// Drives consider and read requests through the start/busy port and changes
// the list capacity between phases. A scoreboard keeps its own copy of the
// ranked list, predicts each response, and checks every strobed response
// against the oldest prediction.
// ----------------------------------------------------------------------------

// Function codes of a request.
localparam logic FUNC_CONSIDER = 1'b0;
localparam logic FUNC_READ     = 1'b1;

// One request as driven onto the req_ ports.
typedef struct packed {
   logic                            func;
   logic [tksi_pkg::SCORE_W-1:0]    score;
   logic [tksi_pkg::PICK_W-1:0]     pick_a;
   logic [tksi_pkg::PICK_W-1:0]     pick_b;
   logic [tksi_pkg::PICK_W-1:0]     pick_c;
   logic [tksi_pkg::RANK_W-1:0]     read_rank;
} request_type;

// One response as seen on the rsp_ ports.
typedef struct packed {
   logic                            accepted;
   logic [tksi_pkg::RANK_W-1:0]     insert_pos;
   logic                            entry_valid;
   logic [tksi_pkg::SCORE_W-1:0]    entry_score;
   logic [tksi_pkg::PICK_W-1:0]     entry_a;
   logic [tksi_pkg::PICK_W-1:0]     entry_b;
   logic [tksi_pkg::PICK_W-1:0]     entry_c;
   logic [tksi_pkg::CAP_W-1:0]      entry_count;
} outcome_type;

// Scoreboard: mirrors the ranked list and queues the expected responses.
class topk_list_board;
   tksi_pkg::entry_type          ranked_slots [tksi_pkg::MAX_ENTRIES_DEF];
   int unsigned                  held_entries;
   logic [tksi_pkg::CAP_W-1:0]   capacity_reg;
   outcome_type                  expected_outcomes [$];
   int unsigned                  failures;
   int unsigned                  considers, placed, dropped, reads, read_hits, deepest;

   function new();
      capacity_reg = 5'd1;
      held_entries = 0;
   endfunction

   // A capacity write also empties the list.
   function void load_capacity(logic [tksi_pkg::CAP_W-1:0] value);
      capacity_reg = value;
      held_entries = 0;
   endfunction

   // Works out the response of an accepted request and updates the list.
   function void predict_request(request_type r);
      outcome_type res;
      int unsigned cap;
      int unsigned slot;
      bit          full;
      cap = 32'(capacity_reg);
      if (cap < 1) cap = 1;
      if (cap > tksi_pkg::MAX_ENTRIES_DEF) cap = tksi_pkg::MAX_ENTRIES_DEF;
      res = '0;
      if (r.func == FUNC_CONSIDER) begin
         considers++;
         full = (held_entries == cap);
         if (full && r.score <= ranked_slots[held_entries-1].score) begin
            dropped++;
         end else begin
            if (full) begin
               slot = held_entries - 1;
            end else begin
               slot = held_entries;
               held_entries++;
            end
            // Smaller scores move down one rank; equal scores stay ahead.
            while (slot > 0 && ranked_slots[slot-1].score < r.score) begin
               ranked_slots[slot] = ranked_slots[slot-1];
               slot--;
            end
            ranked_slots[slot].score  = r.score;
            ranked_slots[slot].pick_a = r.pick_a;
            ranked_slots[slot].pick_b = r.pick_b;
            ranked_slots[slot].pick_c = r.pick_c;
            res.accepted   = 1'b1;
            res.insert_pos = 4'(slot);
            placed++;
            if (held_entries > deepest) deepest = held_entries;
         end
      end else begin
         reads++;
         // Ranks at or past the count read back as empty.
         if (r.read_rank < held_entries) begin
            res.entry_valid = 1'b1;
            res.entry_score = ranked_slots[r.read_rank].score;
            res.entry_a     = ranked_slots[r.read_rank].pick_a;
            res.entry_b     = ranked_slots[r.read_rank].pick_b;
            res.entry_c     = ranked_slots[r.read_rank].pick_c;
            read_hits++;
         end
      end
      res.entry_count = 5'(held_entries);
      expected_outcomes = {expected_outcomes, res};
   endfunction

   // Checks one strobed response against the oldest expected one.
   function void compare_response(outcome_type got);
      outcome_type want;
      if (expected_outcomes.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: response with nothing expected: acc=%0b pos=%0d count=%0d",
                     got.accepted, got.insert_pos, got.entry_count);
         return;
      end
      want = expected_outcomes.pop_front();
      if (got.accepted !== want.accepted || got.insert_pos !== want.insert_pos ||
          got.entry_valid !== want.entry_valid || got.entry_score !== want.entry_score ||
          got.entry_a !== want.entry_a || got.entry_b !== want.entry_b ||
          got.entry_c !== want.entry_c || got.entry_count !== want.entry_count) begin
         failures++;
         if (failures <= 10) begin
            $display("ERROR: mismatch at %0t", $realtime);
            $display("  expected acc=%0b pos=%0d valid=%0b score=%h a=%h b=%h c=%h count=%0d",
                     want.accepted, want.insert_pos, want.entry_valid, want.entry_score,
                     want.entry_a, want.entry_b, want.entry_c, want.entry_count);
            $display("  actual   acc=%0b pos=%0d valid=%0b score=%h a=%h b=%h c=%h count=%0d",
                     got.accepted, got.insert_pos, got.entry_valid, got.entry_score,
                     got.entry_a, got.entry_b, got.entry_c, got.entry_count);
         end
      end
   endfunction
endclass

module tb;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_func = FUNC_CONSIDER;
   logic [tksi_pkg::SCORE_W-1:0]    req_score = '0;
   logic [tksi_pkg::PICK_W-1:0]     req_pick_a = '0;
   logic [tksi_pkg::PICK_W-1:0]     req_pick_b = '0;
   logic [tksi_pkg::PICK_W-1:0]     req_pick_c = '0;
   logic [tksi_pkg::RANK_W-1:0]     req_read_rank = '0;
   logic                            csr_write_en = 1'b0;
   logic [tksi_pkg::CAP_W-1:0]      csr_list_capacity = 5'd1;
   logic                            rsp_strobe;
   logic                            rsp_accepted;
   logic [tksi_pkg::RANK_W-1:0]     rsp_insert_pos;
   logic                            rsp_entry_valid;
   logic [tksi_pkg::SCORE_W-1:0]    rsp_entry_score;
   logic [tksi_pkg::PICK_W-1:0]     rsp_entry_a;
   logic [tksi_pkg::PICK_W-1:0]     rsp_entry_b;
   logic [tksi_pkg::PICK_W-1:0]     rsp_entry_c;
   logic [tksi_pkg::CAP_W-1:0]      rsp_entry_count;

   topk_list_board board = new();
   int unsigned    settings_applied = 0;

   // Capacities for the first random phases: extremes and out-of-range values.
   logic [tksi_pkg::CAP_W-1:0] capacity_plan [10] =
      '{5'd16, 5'd1, 5'd31, 5'd8, 5'd17, 5'd0, 5'd3, 5'd16, 5'd12, 5'd2};

   top_k_sorted_insert u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_score         (req_score),
      .req_pick_a        (req_pick_a),
      .req_pick_b        (req_pick_b),
      .req_pick_c        (req_pick_c),
      .req_read_rank     (req_read_rank),
      .csr_write_en      (csr_write_en),
      .csr_list_capacity (csr_list_capacity),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted),
      .rsp_insert_pos    (rsp_insert_pos),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_entry_score   (rsp_entry_score),
      .rsp_entry_a       (rsp_entry_a),
      .rsp_entry_b       (rsp_entry_b),
      .rsp_entry_c       (rsp_entry_c),
      .rsp_entry_count   (rsp_entry_count)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Every strobed response is checked in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0)
         board.compare_response({rsp_accepted, rsp_insert_pos, rsp_entry_valid,
                                 rsp_entry_score, rsp_entry_a, rsp_entry_b,
                                 rsp_entry_c, rsp_entry_count});
   end

   function automatic request_type make_consider(logic [31:0] score, logic [15:0] a,
                                                 logic [15:0] b, logic [15:0] c);
      request_type r;
      r = '0;
      r.func   = FUNC_CONSIDER;
      r.score  = score;
      r.pick_a = a;
      r.pick_b = b;
      r.pick_c = c;
      return r;
   endfunction

   function automatic request_type make_read(logic [3:0] rank);
      request_type r;
      r = '0;
      r.func      = FUNC_READ;
      r.read_rank = rank;
      return r;
   endfunction

   // Random request; scores mix tight clusters for ties with the full range.
   function automatic request_type random_request(int unsigned cap);
      request_type r;
      int unsigned top_rank;
      r.func = ($urandom_range(0, 99) < 35) ? FUNC_READ : FUNC_CONSIDER;
      case ($urandom_range(0, 5))
         0: begin
            r.score = $urandom_range(0, 7);
         end
         1: begin
            r.score = $urandom();
         end
         2: begin
            r.score = $urandom_range(0, 32'h8000_0000);
         end
         3: begin
            case ($urandom_range(0, 3))
               0:       r.score = 32'h0000_0000;
               1:       r.score = 32'h8000_0000;
               2:       r.score = 32'hFFFF_FFFF;
               default: r.score = 32'h7FFF_FFFF;
            endcase
         end
         default: begin
            r.score = 32'h4000_0000 + $urandom_range(0, 63);
         end
      endcase
      r.pick_a = 16'($urandom());
      r.pick_b = 16'($urandom());
      r.pick_c = 16'($urandom());
      top_rank = (cap > 15) ? 15 : cap;
      if ($urandom_range(0, 3) != 0)
         r.read_rank = 4'($urandom_range(0, top_rank));
      else
         r.read_rank = 4'($urandom_range(0, 15));
      return r;
   endfunction

   // Presents one request and holds it until the block takes it.
   task automatic issue_request(request_type r);
      start         <= 1'b1;
      req_func      <= r.func;
      req_score     <= r.score;
      req_pick_a    <= r.pick_a;
      req_pick_b    <= r.pick_b;
      req_pick_c    <= r.pick_c;
      req_read_rank <= r.read_rank;
      do @(posedge clock); while (busy !== 1'b0);
      board.predict_request(r);
   endtask

   // Random idle cycles between requests, unless in the quiet stretch.
   task automatic sender_gap(bit quiet);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Stops issuing and waits until every expected response has arrived.
   task automatic settle_list();
      start <= 1'b0;
      while (board.expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic set_list_capacity(logic [4:0] value);
      settle_list();
      csr_list_capacity <= value;
      csr_write_en      <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.load_capacity(value);
      settings_applied++;
   endtask

   // Main stimulus.
   initial begin
      int unsigned phase;
      int unsigned span;
      int unsigned random_sent;
      int unsigned eff_cap;
      logic [4:0]  cap_value;
      phase       = 0;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity of one: empty read, tie drop, replacement, reads.
      issue_request(make_read(4'd0));
      issue_request(make_consider(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000));
      issue_request(make_consider(32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      issue_request(make_consider(32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      issue_request(make_read(4'd0));
      issue_request(make_read(4'd15));

      // Capacity four: ties keep arrival order, tail drop and mid insertion.
      set_list_capacity(5'd4);
      issue_request(make_consider(32'hFFFF_FFFF, 16'hA5A5, 16'h5A5A, 16'h0F0F));
      issue_request(make_consider(32'd100, 16'd1, 16'd1, 16'd1));
      issue_request(make_consider(32'd100, 16'd2, 16'd2, 16'd2));
      issue_request(make_consider(32'd100, 16'd3, 16'd3, 16'd3));
      issue_request(make_consider(32'd100, 16'd4, 16'd4, 16'd4));
      issue_request(make_consider(32'd200, 16'd5, 16'd5, 16'd5));
      issue_request(make_read(4'd0));
      issue_request(make_read(4'd1));
      issue_request(make_read(4'd2));
      issue_request(make_read(4'd3));
      issue_request(make_read(4'd4));

      // Capacity zero behaves as one.
      set_list_capacity(5'd0);
      issue_request(make_consider(32'd5, 16'h1234, 16'h5678, 16'h9ABC));
      issue_request(make_consider(32'd6, 16'hFEDC, 16'hBA98, 16'h7654));
      issue_request(make_read(4'd0));

      // Random phases, each with its own capacity.
      while (random_sent < 1850) begin
         cap_value = (phase < 10) ? capacity_plan[phase] : 5'($urandom_range(0, 31));
         set_list_capacity(cap_value);
         eff_cap = (cap_value == 0) ? 1 : (cap_value > 16) ? 16 : 32'(cap_value);
         span = $urandom_range(80, 160);
         if (span > 1850 - random_sent) span = 1850 - random_sent;
         repeat (span) begin
            sender_gap(random_sent >= 700 && random_sent < 1000);
            issue_request(random_request(eff_cap));
            random_sent++;
         end
         phase++;
      end

      // Drain, then allow a worst-case insertion time for stray responses.
      settle_list();
      repeat (24) @(posedge clock);
      if (board.expected_outcomes.size() != 0) begin
         board.failures++;
         $display("ERROR: %0d responses never arrived", board.expected_outcomes.size());
      end
      $display("Ran %0d requests over %0d capacity settings; list depth reached %0d.",
               board.considers + board.reads, settings_applied, board.deepest);
      $display("Considers %0d (placed %0d, dropped %0d), reads %0d (%0d in range), errors %0d.",
               board.considers, board.placed, board.dropped, board.reads, board.read_hits,
               board.failures);
      if (board.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #5_000_000;
      $display("ERROR: run did not finish in time");
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/tksi_pkg.sv
hdl/tksi_ctrl.sv
hdl/tksi_dpath.sv
hdl/top_k_sorted_insert.sv
hdl/tksi_checker.sv
verif/tb.sv
